// ===== hdl/hld_pkg.sv =====
// Shared types, constants and helpers for the tree path decomposition engine.
`timescale 1ns / 1ps

package hld_pkg;

  localparam int NODE_W     = 10;
  localparam int MAX_NODES  = 1023;
  localparam int NODE_DEPTH = 2 ** NODE_W;
  localparam int MAX_EDGES  = MAX_NODES - 1;
  localparam int ADJ_DEPTH  = 2 * MAX_EDGES;
  localparam int ADJ_W      = $clog2(ADJ_DEPTH + 1);
  localparam int EDGE_AW    = $clog2(MAX_EDGES);
  localparam int ADJ_AW     = $clog2(ADJ_DEPTH);
  localparam int STK_AW     = $clog2(NODE_DEPTH);

  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_LCA   = 2'd2;
  localparam logic [1:0] OP_PATH  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_NO_BUILD = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] depth;
    logic [NODE_W-1:0] parent;
    logic [NODE_W-1:0] size;
    logic [NODE_W-1:0] heavy;
    logic [NODE_W-1:0] top;
    logic [NODE_W-1:0] pre;
    logic [ADJ_W-1:0]  adj_lo;
    logic [ADJ_W-1:0]  adj_hi;
    logic [ADJ_W-1:0]  fill;
  } node_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [ADJ_W-1:0]  cursor;
  } stk_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [NODE_W-1:0] ancestor;
    logic [NODE_W-1:0] range_low;
    logic [NODE_W-1:0] range_high;
    logic              last;
  } res_t;

  function automatic res_t make_result(input logic [1:0] kind, input logic [1:0] status,
                                       input logic [NODE_W-1:0] anc,
                                       input logic [NODE_W-1:0] lo,
                                       input logic [NODE_W-1:0] hi, input logic last);
    res_t r;
    r.kind       = kind;
    r.status     = status;
    r.ancestor   = anc;
    r.range_low  = lo;
    r.range_high = hi;
    r.last       = last;
    return r;
  endfunction

endpackage

// ===== hdl/hld_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module hld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/hld_out_stage.sv =====
// Output register for result items, decoupling the engine from the consumer.
`timescale 1ns / 1ps

module hld_out_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  hld_pkg::res_t              res,
  output logic                       ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 kind,
  output logic [1:0]                 status,
  output logic [hld_pkg::NODE_W-1:0] ancestor,
  output logic [hld_pkg::NODE_W-1:0] range_low,
  output logic [hld_pkg::NODE_W-1:0] range_high,
  output logic                       last
);

  hld_pkg::res_t held;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

  assign kind       = held.kind;
  assign status     = held.status;
  assign ancestor   = held.ancestor;
  assign range_low  = held.range_low;
  assign range_high = held.range_high;
  assign last       = held.last;

endmodule

// ===== hdl/tree_path_decomposition_core.sv =====
// Top level: heavy-light decomposition engine with edge, adjacency, node and stack memories.
`timescale 1ns / 1ps

// Heavy-light decomposition engine for a tree of up to 1023 nodes numbered from 1. One item
// is worked at a time; every step is a read-modify-write of the node memory, whose read data
// is registered. A build first runs a clearing pass over all 1024 node memory entries, then
// sweeps the stored edges to form the adjacency lists, sets the list offsets of each node and
// makes the two tree walks. An ancestor or path query climbs chain segments until both nodes
// share a chain, and a path query delivers a result for each segment crossed. Results leave
// through a one-entry output register, so a new item is taken while the last result of the
// previous one is still waiting.
module tree_path_decomposition_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [9:0]                 cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 opcode,
  input  logic [hld_pkg::NODE_W-1:0] node_a,
  input  logic [hld_pkg::NODE_W-1:0] node_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 kind,
  output logic [1:0]                 status,
  output logic [hld_pkg::NODE_W-1:0] ancestor,
  output logic [hld_pkg::NODE_W-1:0] range_low,
  output logic [hld_pkg::NODE_W-1:0] range_high,
  output logic                       last
);

  localparam int NW = hld_pkg::NODE_W;
  localparam int AW = hld_pkg::ADJ_W;

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_DISP   = 6'd1;
  localparam logic [5:0] S_CLR    = 6'd2;
  localparam logic [5:0] S_E      = 6'd3;
  localparam logic [5:0] S_EW     = 6'd4;
  localparam logic [5:0] S_A      = 6'd5;
  localparam logic [5:0] S_BR     = 6'd6;
  localparam logic [5:0] S_B      = 6'd7;
  localparam logic [5:0] S_PRE_R  = 6'd8;
  localparam logic [5:0] S_PRE_W  = 6'd9;
  localparam logic [5:0] S_M_INIT = 6'd10;
  localparam logic [5:0] S_M_ROOT = 6'd11;
  localparam logic [5:0] S_M_LOOP = 6'd12;
  localparam logic [5:0] S_M_V    = 6'd13;
  localparam logic [5:0] S_M_VC   = 6'd14;
  localparam logic [5:0] S_M_P1   = 6'd15;
  localparam logic [5:0] S_M_P2   = 6'd16;
  localparam logic [5:0] S_M_P3   = 6'd17;
  localparam logic [5:0] S_N_INIT = 6'd18;
  localparam logic [5:0] S_N_ER   = 6'd19;
  localparam logic [5:0] S_N_EW   = 6'd20;
  localparam logic [5:0] S_N_LOOP = 6'd21;
  localparam logic [5:0] S_N_V    = 6'd22;
  localparam logic [5:0] S_N_VC   = 6'd23;
  localparam logic [5:0] S_N_P1   = 6'd24;
  localparam logic [5:0] S_N_P2   = 6'd25;
  localparam logic [5:0] S_BDONE  = 6'd26;
  localparam logic [5:0] S_Q_RB   = 6'd27;
  localparam logic [5:0] S_Q_CHK  = 6'd28;
  localparam logic [5:0] S_Q_LOOP = 6'd29;
  localparam logic [5:0] S_Q_T1   = 6'd30;
  localparam logic [5:0] S_Q_T2   = 6'd31;
  localparam logic [5:0] S_Q_RU   = 6'd32;
  localparam logic [5:0] S_Q_T3   = 6'd33;
  localparam logic [5:0] S_EMIT   = 6'd34;

  logic [5:0]    state;
  logic [5:0]    ret;
  logic [NW-1:0] ncount;
  logic          built;
  logic [hld_pkg::EDGE_AW-1:0] edge_total;
  logic [NW-1:0] pcount;
  logic [1:0]    op;
  logic [NW-1:0] na;
  logic [NW-1:0] nb;
  logic [AW-1:0] idx;
  logic [AW-1:0] run;
  logic          fillmode;
  logic [NW-1:0] ea;
  logic [NW-1:0] eb;
  logic [AW-1:0] sp;
  logic [NW-1:0] cu;
  logic [AW-1:0] cc;
  logic [AW-1:0] chi;
  logic [NW-1:0] cdep;
  logic [NW-1:0] cheavy;
  logic [NW-1:0] xv;
  logic [NW-1:0] xtop;
  logic [NW-1:0] xp;
  logic [AW-1:0] xpc;
  logic [NW-1:0] usize;
  hld_pkg::node_t pw;
  hld_pkg::node_t tu;
  hld_pkg::node_t wu;
  hld_pkg::node_t wv;
  logic [NW-1:0] qu;
  logic [NW-1:0] qv;
  hld_pkg::res_t pend;

  logic out_ready;
  logic push;

  // memory ports
  logic                        node_we;
  logic [NW-1:0]               node_waddr;
  hld_pkg::node_t              node_wdata;
  logic [NW-1:0]               node_raddr;
  hld_pkg::node_t              node_rd;
  logic                        edge_we;
  logic [2*NW-1:0]             edge_wdata;
  logic [2*NW-1:0]             edge_rd;
  logic                        adj_we;
  logic [hld_pkg::ADJ_AW-1:0]  adj_waddr;
  logic [NW-1:0]               adj_wdata;
  logic [hld_pkg::ADJ_AW-1:0]  adj_raddr;
  logic [NW-1:0]               adj_rd;
  logic                        stk_we;
  logic [hld_pkg::STK_AW-1:0]  stk_waddr;
  hld_pkg::stk_t               stk_wdata;
  logic [hld_pkg::STK_AW-1:0]  stk_raddr;
  hld_pkg::stk_t               stk_rd;

  logic [NW-1:0] acnt;
  logic          a_ok;
  logic          b_ok;
  logic          ea_ok;
  logic          eb_ok;
  logic [NW-1:0] dnext;
  logic [AW-1:0] sp_m1;
  logic [AW-1:0] sp_m2;
  logic          qswap;
  logic [NW-1:0] new_heavy;

  assign acnt  = (ncount > NW'(hld_pkg::MAX_NODES)) ? NW'(hld_pkg::MAX_NODES) : ncount;
  assign a_ok  = (na != '0) && (na <= acnt);
  assign b_ok  = (nb != '0) && (nb <= acnt);
  assign ea_ok = (edge_rd[2*NW-1:NW] != '0) && (edge_rd[2*NW-1:NW] <= acnt);
  assign eb_ok = (edge_rd[NW-1:0] != '0) && (edge_rd[NW-1:0] <= acnt);
  // depth wraps past the top and skips zero
  assign dnext = (cdep == '1) ? NW'(1) : cdep + NW'(1);
  assign sp_m1 = sp - AW'(1);
  assign sp_m2 = sp - AW'(2);
  assign qswap = tu.depth < node_rd.depth;
  assign new_heavy = (pw.heavy == '0 || usize > node_rd.size) ? cu : pw.heavy;

  assign in_stall = (state != S_IDLE);
  assign push     = (state == S_EMIT) && out_ready;

  hld_ram #(.WIDTH($bits(hld_pkg::node_t)), .DEPTH(hld_pkg::NODE_DEPTH)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rd)
  );

  hld_ram #(.WIDTH(2 * NW), .DEPTH(hld_pkg::MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_total), .wdata(edge_wdata),
    .raddr(idx[hld_pkg::EDGE_AW-1:0]), .rdata(edge_rd)
  );

  hld_ram #(.WIDTH(NW), .DEPTH(hld_pkg::ADJ_DEPTH)) u_adj_ram (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rd)
  );

  hld_ram #(.WIDTH($bits(hld_pkg::stk_t)), .DEPTH(hld_pkg::NODE_DEPTH)) u_stk_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  hld_out_stage u_out (
    .clk(clk), .rst(rst), .push(push), .res(pend), .ready(out_ready),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .status(status),
    .ancestor(ancestor), .range_low(range_low), .range_high(range_high), .last(last)
  );

  // memory control, decoded from the state
  always_comb begin
    node_we    = 1'b0;
    node_waddr = idx[NW-1:0];
    node_wdata = node_rd;
    node_raddr = cu;
    edge_we    = 1'b0;
    edge_wdata = {na, nb};
    adj_we     = 1'b0;
    adj_waddr  = node_rd.fill[hld_pkg::ADJ_AW-1:0];
    adj_wdata  = eb;
    adj_raddr  = cc[hld_pkg::ADJ_AW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = sp_m1[hld_pkg::STK_AW-1:0];
    stk_wdata  = '{node: cu, cursor: cc};
    stk_raddr  = sp_m2[hld_pkg::STK_AW-1:0];
    case (state)
      S_DISP: begin
        node_raddr = na;
        edge_we    = (op == hld_pkg::OP_EDGE) && a_ok && b_ok &&
                     (edge_total < hld_pkg::EDGE_AW'(hld_pkg::MAX_EDGES));
      end
      S_CLR: begin
        node_we    = 1'b1;
        node_wdata = '0;
      end
      S_EW: node_raddr = edge_rd[2*NW-1:NW];
      S_A: begin
        node_we         = 1'b1;
        node_waddr      = ea;
        node_wdata.fill = node_rd.fill + AW'(1);
        adj_we          = fillmode;
        adj_wdata       = eb;
      end
      S_BR: node_raddr = eb;
      S_B: begin
        node_we         = 1'b1;
        node_waddr      = eb;
        node_wdata.fill = node_rd.fill + AW'(1);
        adj_we          = fillmode;
        adj_wdata       = ea;
      end
      S_PRE_R: node_raddr = idx[NW-1:0];
      S_PRE_W: begin
        node_we           = 1'b1;
        node_wdata.adj_lo = run;
        node_wdata.adj_hi = run + node_rd.fill;
        node_wdata.fill   = run;
      end
      S_M_INIT: node_raddr = na;
      S_M_ROOT: begin
        node_we           = 1'b1;
        node_waddr        = na;
        node_wdata.depth  = NW'(1);
        node_wdata.size   = NW'(1);
        node_wdata.parent = '0;
      end
      S_M_V: node_raddr = adj_rd;
      S_M_VC: begin
        if (node_rd.depth == '0) begin
          node_we           = 1'b1;
          node_waddr        = xv;
          node_wdata.depth  = dnext;
          node_wdata.parent = cu;
          node_wdata.size   = NW'(1);
          stk_we            = 1'b1;
        end
      end
      S_M_P1: node_raddr = stk_rd.node;
      S_M_P2: node_raddr = node_rd.heavy;
      S_M_P3: begin
        node_we          = 1'b1;
        node_waddr       = xp;
        node_wdata       = pw;
        node_wdata.size  = pw.size + usize;
        node_wdata.heavy = new_heavy;
      end
      S_N_ER: node_raddr = xv;
      S_N_EW: begin
        node_we        = 1'b1;
        node_waddr     = xv;
        node_wdata.top = xtop;
        node_wdata.pre = pcount + NW'(1);
        stk_we         = (sp != '0);
      end
      S_N_V: node_raddr = adj_rd;
      S_N_P1: node_raddr = stk_rd.node;
      S_Q_RB: node_raddr = nb;
      S_Q_LOOP: node_raddr = wu.top;
      S_Q_T1: node_raddr = wv.top;
      S_Q_RU: node_raddr = qu;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      ncount     <= NW'(1);
      built      <= 1'b0;
      edge_total <= '0;
      pcount     <= '0;
      sp         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= opcode;
            na    <= node_a;
            nb    <= node_b;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          ret   <= S_IDLE;
          state <= S_EMIT;
          case (op)
            hld_pkg::OP_EDGE: begin
              if (edge_we) begin
                edge_total <= edge_total + hld_pkg::EDGE_AW'(1);
                built      <= 1'b0;
                pend <= hld_pkg::make_result(op, hld_pkg::ST_OK, '0, '0, '0, 1'b1);
              end else begin
                pend <= hld_pkg::make_result(op, hld_pkg::ST_BAD, '0, '0, '0, 1'b1);
              end
            end
            hld_pkg::OP_BUILD: begin
              if (a_ok) begin
                idx      <= '0;
                fillmode <= 1'b0;
                pcount   <= '0;
                state    <= S_CLR;
              end else begin
                pend <= hld_pkg::make_result(op, hld_pkg::ST_BAD, '0, '0, '0, 1'b1);
              end
            end
            default: begin
              if (!built) begin
                pend <= hld_pkg::make_result(op, hld_pkg::ST_NO_BUILD, '0, '0, '0, 1'b1);
              end else if (!a_ok || !b_ok) begin
                pend <= hld_pkg::make_result(op, hld_pkg::ST_BAD, '0, '0, '0, 1'b1);
              end else begin
                state <= S_Q_RB;
              end
            end
          endcase
        end
        S_CLR: begin
          idx <= idx + AW'(1);
          if (idx == AW'(hld_pkg::NODE_DEPTH - 1)) begin
            idx   <= '0;
            state <= S_E;
          end
        end
        // edge sweep: counts degrees, then on the second sweep fills the lists
        S_E: begin
          if (idx == AW'(edge_total)) begin
            idx <= fillmode ? idx : AW'(1);
            run <= '0;
            state <= fillmode ? S_M_INIT : S_PRE_R;
          end else begin
            state <= S_EW;
          end
        end
        S_EW: begin
          ea <= edge_rd[2*NW-1:NW];
          eb <= edge_rd[NW-1:0];
          if (ea_ok && eb_ok) begin
            state <= S_A;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_E;
          end
        end
        S_A:  state <= S_BR;
        S_BR: state <= S_B;
        S_B: begin
          idx   <= idx + AW'(1);
          state <= S_E;
        end
        S_PRE_R: begin
          if (idx > AW'(acnt)) begin
            idx      <= '0;
            fillmode <= 1'b1;
            state    <= S_E;
          end else begin
            state <= S_PRE_W;
          end
        end
        S_PRE_W: begin
          run   <= run + node_rd.fill;
          idx   <= idx + AW'(1);
          state <= S_PRE_R;
        end
        S_M_INIT: state <= S_M_ROOT;
        S_M_ROOT: begin
          cu    <= na;
          cc    <= node_rd.adj_lo;
          chi   <= node_rd.adj_hi;
          cdep  <= NW'(1);
          sp    <= AW'(1);
          state <= S_M_LOOP;
        end
        S_M_LOOP: begin
          if (cc < chi) begin
            cc    <= cc + AW'(1);
            state <= S_M_V;
          end else begin
            state <= S_M_P1;
          end
        end
        S_M_V: begin
          xv    <= adj_rd;
          state <= S_M_VC;
        end
        S_M_VC: begin
          if (node_rd.depth == '0) begin
            sp   <= sp + AW'(1);
            cu   <= xv;
            cc   <= node_rd.adj_lo;
            chi  <= node_rd.adj_hi;
            cdep <= dnext;
          end
          state <= S_M_LOOP;
        end
        S_M_P1: begin
          usize <= node_rd.size;
          xp    <= stk_rd.node;
          xpc   <= stk_rd.cursor;
          state <= (sp == AW'(1)) ? S_N_INIT : S_M_P2;
        end
        S_M_P2: begin
          pw    <= node_rd;
          state <= S_M_P3;
        end
        // fold the finished child into its parent, which becomes the walk top again
        S_M_P3: begin
          sp    <= sp_m1;
          cu    <= xp;
          cc    <= xpc;
          chi   <= pw.adj_hi;
          cdep  <= pw.depth;
          state <= S_M_LOOP;
        end
        S_N_INIT: begin
          sp    <= '0;
          xv    <= na;
          xtop  <= na;
          state <= S_N_ER;
        end
        S_N_ER: state <= S_N_EW;
        S_N_EW: begin
          pcount <= pcount + NW'(1);
          sp     <= sp + AW'(1);
          cu     <= xv;
          cc     <= node_rd.adj_lo;
          chi    <= node_rd.adj_hi;
          cheavy <= node_rd.heavy;
          xv     <= node_rd.heavy;
          state  <= (node_rd.heavy != '0) ? S_N_ER : S_N_LOOP;
        end
        S_N_LOOP: begin
          if (cc < chi) begin
            cc    <= cc + AW'(1);
            state <= S_N_V;
          end else begin
            sp    <= sp_m1;
            state <= (sp == AW'(1)) ? S_BDONE : S_N_P1;
          end
        end
        S_N_V: begin
          xv    <= adj_rd;
          state <= S_N_VC;
        end
        S_N_VC: begin
          if (node_rd.parent == cu && xv != cheavy && node_rd.pre == '0) begin
            xtop  <= xv;
            state <= S_N_ER;
          end else begin
            state <= S_N_LOOP;
          end
        end
        S_N_P1: begin
          cu    <= stk_rd.node;
          cc    <= stk_rd.cursor;
          state <= S_N_P2;
        end
        S_N_P2: begin
          chi    <= node_rd.adj_hi;
          cheavy <= node_rd.heavy;
          state  <= S_N_LOOP;
        end
        S_BDONE: begin
          built <= 1'b1;
          pend  <= hld_pkg::make_result(op, hld_pkg::ST_OK, '0, '0, '0, 1'b1);
          ret   <= S_IDLE;
          state <= S_EMIT;
        end
        S_Q_RB: begin
          wu    <= node_rd;
          state <= S_Q_CHK;
        end
        S_Q_CHK: begin
          wv <= node_rd;
          qu <= na;
          qv <= nb;
          if (wu.depth == '0 || node_rd.depth == '0) begin
            pend  <= hld_pkg::make_result(op, hld_pkg::ST_BAD, '0, '0, '0, 1'b1);
            ret   <= S_IDLE;
            state <= S_EMIT;
          end else begin
            state <= S_Q_LOOP;
          end
        end
        S_Q_LOOP: begin
          if (wu.top == wv.top) begin
            ret   <= S_IDLE;
            state <= S_EMIT;
            if (op == hld_pkg::OP_LCA) begin
              pend <= hld_pkg::make_result(op, hld_pkg::ST_OK,
                                           (wu.depth < wv.depth) ? qu : qv, '0, '0, 1'b1);
            end else if (wu.depth > wv.depth) begin
              pend <= hld_pkg::make_result(op, hld_pkg::ST_OK, '0, wv.pre, wu.pre, 1'b1);
            end else begin
              pend <= hld_pkg::make_result(op, hld_pkg::ST_OK, '0, wu.pre, wv.pre, 1'b1);
            end
          end else begin
            state <= S_Q_T1;
          end
        end
        S_Q_T1: begin
          tu    <= node_rd;
          state <= S_Q_T2;
        end
        // climb from whichever side has the deeper chain top
        S_Q_T2: begin
          if (qswap) begin
            pend <= hld_pkg::make_result(op, hld_pkg::ST_OK, '0, node_rd.pre, wv.pre, 1'b0);
            qu   <= node_rd.parent;
            qv   <= qu;
            wv   <= wu;
          end else begin
            pend <= hld_pkg::make_result(op, hld_pkg::ST_OK, '0, tu.pre, wu.pre, 1'b0);
            qu   <= tu.parent;
          end
          ret   <= S_Q_RU;
          state <= (op == hld_pkg::OP_PATH) ? S_EMIT : S_Q_RU;
        end
        S_Q_RU: state <= S_Q_T3;
        S_Q_T3: begin
          wu    <= node_rd;
          state <= S_Q_LOOP;
        end
        S_EMIT: begin
          if (out_ready) begin
            state <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we) begin
        ncount <= cfg_wdata;
        built  <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_take_then_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("engine took an item but did not go busy");

  a_cfg_clears_built: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !built)
    else $error("register write did not invalidate the decomposition");

  a_walk_has_top: assert property (@(posedge clk) disable iff (rst)
    (state == S_M_LOOP || state == S_N_LOOP) |-> sp != '0)
    else $error("tree walk running with an empty stack");

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    push |=> state == $past(ret))
    else $error("result transfer did not resume the sequencer");
`endif

endmodule
